@@ rtl/core/flash_region_access_guard_defines.svh @@
// Assertion macros for the flash region access guard.
`ifndef FLASH_REGION_ACCESS_GUARD_DEFINES_SVH
`define FLASH_REGION_ACCESS_GUARD_DEFINES_SVH

// Clocked assertion, disabled while reset is high.
`define FRAG_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same, for properties that must also hold while reset is high.
`define FRAG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/frag_pkg.sv @@
// Shared types, codes and descriptor layout for the flash region access guard.
package frag_pkg;

   localparam int unsigned ADDR_W = 24;
   localparam int unsigned LEN_W  = 13;
   localparam logic [LEN_W-1:0]  MAX_LENGTH  = 13'd4096;
   localparam logic [ADDR_W:0]   FLASH_BYTES = 25'h100_0000;

   localparam logic [ADDR_W-1:0] BIOS_LIMIT = 24'h5F_FFFF;
   localparam logic [ADDR_W-1:0] ME_LIMIT   = 24'h9F_FFFF;
   localparam logic [ADDR_W-1:0] GBE_LIMIT  = 24'hBF_FFFF;
   localparam logic [1:0] BIOS_OWNER = 2'd1;
   localparam logic [1:0] ME_OWNER   = 2'd2;
   localparam logic [1:0] GBE_OWNER  = 2'd3;
   localparam logic [1:0] READ_ONLY_MASTER = 2'd0;

   localparam logic [3:0] LOCK_RESET = 4'b0001;
   localparam int unsigned LK_WE_BIT   = 0;
   localparam int unsigned LK_DOWN_BIT = 3;

   typedef enum logic [1:0] {
      ACT_CHECK = 2'd0,
      ACT_SET   = 2'd1,
      ACT_LOCK  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_REGION_DENY = 3'd1,
      ST_RANGE_PROT  = 3'd2,
      ST_HOST_WP     = 3'd3,
      ST_BOUNDS      = 3'd4,
      ST_BAD_INDEX   = 3'd5,
      ST_BAD_RANGE   = 3'd6,
      ST_LOCKED      = 3'd7
   } status_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_WALK
   } back_state_type;

   typedef struct packed {
      action_type        action;
      logic [1:0]        initiator;
      logic [ADDR_W-1:0] address;
      logic [LEN_W-1:0]  length;
      logic              write_op;
      logic [2:0]        range_index;
      logic [ADDR_W-1:0] range_base;
      logic [ADDR_W-1:0] range_limit;
      logic              wp;
      logic              rp;
      logic [3:0]        lock_request;
      status_type        pre_status;
   } entry_type;

   // Fixed descriptor layout: first region holding the byte decides.
   // Spare regions (base 0, limit 0) are shadowed by the BIOS region.
   function automatic logic region_permits(logic [ADDR_W-1:0] addr, logic [1:0] master);
      logic [1:0] owner;
      logic       hit;
      owner = BIOS_OWNER;
      hit   = 1'b1;
      priority if (addr <= BIOS_LIMIT) owner = BIOS_OWNER;
      else if (addr <= ME_LIMIT)       owner = ME_OWNER;
      else if (addr <= GBE_LIMIT)      owner = GBE_OWNER;
      else                             hit = 1'b0;
      return hit && (master == READ_ONLY_MASTER || master == owner);
   endfunction

endpackage

@@ rtl/core/frag_front.sv @@
// Front end: takes transactions, classifies them and runs stateless checks.
module frag_front import frag_pkg::*; #(
   parameter int unsigned RANGE_COUNT = 5
) (
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_action,
   input  logic [1:0]        req_initiator,
   input  logic [23:0]       req_address,
   input  logic [12:0]       req_length,
   input  logic              req_write_op,
   input  logic [2:0]        req_range_index,
   input  logic [23:0]       req_range_base,
   input  logic [23:0]       req_range_limit,
   input  logic [7:0]        req_permissions,
   input  logic [3:0]        req_lock_request,
   input  logic              q_full,
   output logic              q_push,
   output entry_type         q_entry
);

   logic [ADDR_W:0] end_addr;
   logic            bad_index;

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;
   assign end_addr  = {1'b0, req_address} + {{(ADDR_W+1-LEN_W){1'b0}}, req_length};
   assign bad_index = {29'd0, req_range_index} >= 32'(RANGE_COUNT);

   always_comb begin
      q_entry              = '0;
      q_entry.action       = action_type'(req_action);
      q_entry.initiator    = req_initiator;
      q_entry.address      = req_address;
      q_entry.length       = req_length;
      q_entry.write_op     = req_write_op;
      q_entry.range_index  = req_range_index;
      q_entry.range_base   = req_range_base;
      q_entry.range_limit  = req_range_limit;
      q_entry.wp           = !req_permissions[1];
      q_entry.rp           = !req_permissions[0];
      q_entry.lock_request = req_lock_request;
      q_entry.pre_status   = ST_OK;
      unique case (action_type'(req_action))
         ACT_CHECK: begin
            if (req_length > MAX_LENGTH || end_addr > FLASH_BYTES)
               q_entry.pre_status = ST_BOUNDS;
         end
         ACT_SET: begin
            priority if (bad_index) q_entry.pre_status = ST_BAD_INDEX;
            else if (req_range_base > req_range_limit ||
                     {1'b0, req_range_limit} >= FLASH_BYTES)
               q_entry.pre_status = ST_BAD_RANGE;
         end
         ACT_LOCK, ACT_NONE: q_entry.pre_status = ST_OK;
         default: q_entry.pre_status = ST_OK;
      endcase
   end

endmodule

@@ rtl/core/frag_queue.sv @@
// Two-entry transaction queue between front and back end.
module frag_queue import frag_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head_entry
);

   entry_type mem_ff [2];
   logic      wr_ptr_ff, wr_ptr_in;
   logic      rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = count_ff == 2'd2;
   assign head_valid = count_ff != 2'd0;
   assign head_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

@@ rtl/core/frag_back.sv @@
// Back end: byte walk against region and range tables, range and lock updates.
module frag_back import frag_pkg::*; #(
   parameter int unsigned RANGE_COUNT = 5
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] host_master,
   input  logic       q_valid,
   input  entry_type  q_entry,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_accepted,
   output logic [2:0] rsp_status,
   output logic [3:0] rsp_lock_bits
);

   localparam int unsigned RIDX_W = (RANGE_COUNT > 1) ? $clog2(RANGE_COUNT) : 1;

   back_state_type state_ff, state_in;
   logic [ADDR_W-1:0] base_ff  [RANGE_COUNT];
   logic [ADDR_W-1:0] limit_ff [RANGE_COUNT];
   logic [RANGE_COUNT-1:0] wp_ff, rp_ff;
   logic [3:0] lock_ff, lock_in;

   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [LEN_W-1:0]  remain_ff, remain_in;
   logic [1:0]        master_ff, master_in;
   logic              wr_ff, wr_in;

   logic       out_valid_ff, out_valid_in;
   logic       out_acc_ff, out_acc_in;
   status_type out_st_ff, out_st_in;
   logic [3:0] out_lock_ff, out_lock_in;

   logic       out_free, emit, range_we, load_walk;
   logic       emit_acc;
   status_type emit_st, byte_st;
   logic       range_blk;

   assign out_free      = !out_valid_ff || rsp_ready;
   assign rsp_valid     = out_valid_ff;
   assign rsp_accepted  = out_acc_ff;
   assign rsp_status    = out_st_ff;
   assign rsp_lock_bits = out_lock_ff;

   // First protected range holding the byte decides; scan backwards so index 0 wins.
   always_comb begin
      range_blk = 1'b0;
      for (int i = RANGE_COUNT - 1; i >= 0; i--) begin
         if (addr_ff >= base_ff[i] && addr_ff <= limit_ff[i])
            range_blk = wr_ff ? wp_ff[i] : rp_ff[i];
      end
      priority if (!region_permits(addr_ff, master_ff)) byte_st = ST_REGION_DENY;
      else if (range_blk) byte_st = ST_RANGE_PROT;
      else if (master_ff == host_master && wr_ff && !lock_ff[LK_WE_BIT]) byte_st = ST_HOST_WP;
      else byte_st = ST_OK;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: if (load_walk) state_in = BACK_WALK;
         BACK_WALK: if (emit) state_in = BACK_IDLE;
         default: state_in = BACK_IDLE;
      endcase
   end

   always_comb begin
      q_pop     = 1'b0;
      emit      = 1'b0;
      emit_acc  = 1'b0;
      emit_st   = ST_OK;
      range_we  = 1'b0;
      load_walk = 1'b0;
      lock_in   = lock_ff;
      addr_in   = addr_ff;
      remain_in = remain_ff;
      master_in = master_ff;
      wr_in     = wr_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               unique case (q_entry.action)
                  ACT_CHECK: begin
                     priority if (q_entry.pre_status != ST_OK) begin
                        emit = 1'b1; emit_st = q_entry.pre_status;
                     end else if (q_entry.length == '0) begin
                        emit = 1'b1; emit_acc = 1'b1;
                     end else begin
                        load_walk = 1'b1;
                        addr_in   = q_entry.address;
                        remain_in = q_entry.length;
                        master_in = q_entry.initiator;
                        wr_in     = q_entry.write_op;
                     end
                  end
                  ACT_SET: begin
                     emit = 1'b1;
                     priority if (q_entry.pre_status != ST_OK) emit_st = q_entry.pre_status;
                     else if (lock_ff[LK_DOWN_BIT]) emit_st = ST_LOCKED;
                     else begin
                        range_we = 1'b1; emit_acc = 1'b1;
                     end
                  end
                  ACT_LOCK: begin
                     emit = 1'b1;
                     if (lock_ff[LK_DOWN_BIT]) emit_st = ST_LOCKED;
                     else begin
                        emit_acc = 1'b1;
                        lock_in  = (lock_ff & ~{3'b000, q_entry.lock_request[0]})
                                   | {q_entry.lock_request[3:1], 1'b0};
                     end
                  end
                  ACT_NONE: emit = 1'b1;
                  default: emit = 1'b1;
               endcase
            end
         end
         BACK_WALK: begin
            if (out_free) begin
               priority if (byte_st != ST_OK) begin
                  emit = 1'b1; emit_st = byte_st;
               end else if (remain_ff == LEN_W'(1)) begin
                  emit = 1'b1; emit_acc = 1'b1;
               end else begin
                  addr_in   = addr_ff + ADDR_W'(1);
                  remain_in = remain_ff - LEN_W'(1);
               end
            end
         end
         default: ;
      endcase
      out_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
      out_acc_in   = emit ? emit_acc : out_acc_ff;
      out_st_in    = emit ? emit_st : out_st_ff;
      out_lock_in  = emit ? lock_in : out_lock_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         lock_ff      <= LOCK_RESET;
         out_valid_ff <= 1'b0;
         wp_ff        <= '0;
         rp_ff        <= '0;
         for (int i = 0; i < RANGE_COUNT; i++) begin
            base_ff[i]  <= '1;
            limit_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         lock_ff      <= lock_in;
         out_valid_ff <= out_valid_in;
         if (range_we) begin
            base_ff[q_entry.range_index[RIDX_W-1:0]]  <= q_entry.range_base;
            limit_ff[q_entry.range_index[RIDX_W-1:0]] <= q_entry.range_limit;
            wp_ff[q_entry.range_index[RIDX_W-1:0]]    <= q_entry.wp;
            rp_ff[q_entry.range_index[RIDX_W-1:0]]    <= q_entry.rp;
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      remain_ff   <= remain_in;
      master_ff   <= master_in;
      wr_ff       <= wr_in;
      out_acc_ff  <= out_acc_in;
      out_st_ff   <= out_st_in;
      out_lock_ff <= out_lock_in;
   end

endmodule

@@ rtl/core/flash_region_access_guard.sv @@
// Flash region access guard. Each request transaction gives one response. Access checks
// walk the access one byte per cycle, while the response register is free, against the
// fixed descriptor regions and the protected range slots, stopping at the first refused
// byte; zero-length and out-of-bounds checks, range sets, lock requests and unknown
// actions need no walk. The response appears in the response register the cycle after
// the back end finishes. The byte walk sets the rate. A two-entry queue lets new requests
// be taken while the back end is busy, and a response register holds the result until it
// is taken.
module flash_region_access_guard import frag_pkg::*; #(
   parameter int unsigned RANGE_COUNT = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [1:0]  req_initiator,
   input  logic [23:0] req_address,
   input  logic [12:0] req_length,
   input  logic        req_write_op,
   input  logic [2:0]  req_range_index,
   input  logic [23:0] req_range_base,
   input  logic [23:0] req_range_limit,
   input  logic [7:0]  req_permissions,
   input  logic [3:0]  req_lock_request,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_accepted,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_lock_bits
);

   logic [1:0] host_master_ff;
   logic       q_full, q_push, q_pop, q_valid;
   entry_type  push_entry, head_entry;

   always_ff @(posedge clock) begin
      if (reset) host_master_ff <= 2'd0;
      else if (csr_we) host_master_ff <= csr_wdata;
   end

   frag_front #(.RANGE_COUNT(RANGE_COUNT)) u_front (
      .req_valid, .req_ready, .req_action, .req_initiator, .req_address, .req_length,
      .req_write_op, .req_range_index, .req_range_base, .req_range_limit,
      .req_permissions, .req_lock_request,
      .q_full(q_full), .q_push(q_push), .q_entry(push_entry)
   );

   frag_queue u_queue (
      .clock, .reset, .push(q_push), .push_entry(push_entry), .full(q_full),
      .pop(q_pop), .head_valid(q_valid), .head_entry(head_entry)
   );

   frag_back #(.RANGE_COUNT(RANGE_COUNT)) u_back (
      .clock, .reset, .host_master(host_master_ff), .q_valid(q_valid),
      .q_entry(head_entry), .q_pop(q_pop), .rsp_valid, .rsp_ready, .rsp_accepted,
      .rsp_status, .rsp_lock_bits
   );

endmodule

@@ rtl/core/frag_checker.sv @@
// Port-level checker for the flash region access guard, with its bind.
`include "flash_region_access_guard_defines.svh"

module frag_checker import frag_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_accepted,
   input logic [2:0] rsp_status,
   input logic [3:0] rsp_lock_bits
);

   `FRAG_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status), "response dropped or changed while stalled")
   `FRAG_ASSERT(a_acc_ok, clock, reset, rsp_valid && rsp_accepted |-> rsp_status == ST_OK, "accepted transaction with error status")
   `FRAG_ASSERT(a_locked_bit, clock, reset, rsp_valid && rsp_status == ST_LOCKED |-> rsp_lock_bits[LK_DOWN_BIT], "locked-down status without lockdown bit")
   `FRAG_ASSERT(a_lockdown_sticky, clock, reset, rsp_valid && rsp_lock_bits[LK_DOWN_BIT] |=> !rsp_valid || rsp_lock_bits[LK_DOWN_BIT], "lockdown bit cleared")

endmodule

bind flash_region_access_guard frag_checker u_frag_checker (.*);

@@ bench/tb_flash_region_access_guard.sv @@
// Testbench for the flash region access guard: random and directed transactions checked against a predictor.
module tb_flash_region_access_guard;
   import frag_pkg::*;

   localparam int NUM_SLOTS = 5;

   class guard_scoreboard;
      logic [23:0] rng_base [NUM_SLOTS];
      logic [23:0] rng_limit [NUM_SLOTS];
      logic        rng_wp [NUM_SLOTS];
      logic        rng_rp [NUM_SLOTS];
      logic [3:0]  lock_now;
      logic [1:0]  host_id;
      logic [7:0]  verdicts [$];
      int          errors;
      int          checked;

      function void clear();
         for (int i = 0; i < NUM_SLOTS; i++) begin
            rng_base[i] = 24'hFFFFFF;
            rng_limit[i] = 24'h0;
            rng_wp[i] = 1'b0;
            rng_rp[i] = 1'b0;
         end
         lock_now = 4'b0001;
         host_id = 2'd0;
         errors = 0;
         checked = 0;
      endfunction

      function bit owns(logic [1:0] m, logic [23:0] a, output bit hit);
         logic [1:0] own;
         hit = 1;
         if (a <= 24'h5FFFFF) own = 2'd1;
         else if (a <= 24'h9FFFFF) own = 2'd2;
         else if (a <= 24'hBFFFFF) own = 2'd3;
         else begin
            hit = 0;
            own = 2'd0;
         end
         return hit && (m == 2'd0 || m == own);
      endfunction

      function status_type access_verdict(logic [1:0] m, logic [23:0] addr,
                                          logic [12:0] len, logic wr);
         bit hit;
         logic [23:0] a;
         if (len > 13'd4096 || ({1'b0, addr} + len) > 25'h1000000) return ST_BOUNDS;
         for (int i = 0; i < len; i++) begin
            a = addr + 24'(i);
            if (!owns(m, a, hit)) return ST_REGION_DENY;
            for (int s = 0; s < NUM_SLOTS; s++)
               if (a >= rng_base[s] && a <= rng_limit[s]) begin
                  if (wr ? rng_wp[s] : rng_rp[s]) return ST_RANGE_PROT;
                  break;
               end
            if (m == host_id && wr && !lock_now[0]) return ST_HOST_WP;
         end
         return ST_OK;
      endfunction

      function void note_request(action_type act, logic [1:0] m, logic [23:0] addr,
                                 logic [12:0] len, logic wr, logic [2:0] idx,
                                 logic [23:0] b, logic [23:0] l, logic [7:0] perm,
                                 logic [3:0] lreq);
         status_type st;
         logic acc;
         st = ST_OK;
         acc = 0;
         case (act)
            ACT_CHECK: begin
               st = access_verdict(m, addr, len, wr);
               acc = (st == ST_OK);
            end
            ACT_SET: begin
               if (idx >= NUM_SLOTS) st = ST_BAD_INDEX;
               else if (b > l) st = ST_BAD_RANGE;
               else if (lock_now[3]) st = ST_LOCKED;
               else begin
                  rng_base[idx] = b;
                  rng_limit[idx] = l;
                  rng_wp[idx] = !perm[1];
                  rng_rp[idx] = !perm[0];
               end
               acc = (st == ST_OK);
            end
            ACT_LOCK: begin
               if (lock_now[3]) st = ST_LOCKED;
               else begin
                  if (lreq[0]) lock_now[0] = 1'b0;
                  lock_now = lock_now | (lreq & 4'hE);
               end
               acc = (st == ST_OK);
            end
            default: ;
         endcase
         verdicts.push_back({acc, st, lock_now});
      endfunction

      function void check_response(logic acc, logic [2:0] st, logic [3:0] lk);
         logic [7:0] e;
         if (verdicts.size() == 0) begin
            $error("response with nothing outstanding");
            errors++;
            return;
         end
         e = verdicts.pop_front();
         checked++;
         if (acc !== e[7]) begin
            $error("accepted: expected %0d actual %0d", e[7], acc); errors++;
         end
         if (st !== e[6:4]) begin
            $error("status: expected %0d actual %0d", e[6:4], st); errors++;
         end
         if (lk !== e[3:0]) begin
            $error("lock_bits: expected %h actual %h", e[3:0], lk); errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic csr_we = 0;
   logic [1:0] csr_wdata = 0;
   logic req_valid = 0, req_ready;
   logic [1:0] req_action = 0, req_initiator = 0;
   logic [23:0] req_address = 0, req_range_base = 0, req_range_limit = 0;
   logic [12:0] req_length = 0;
   logic req_write_op = 0;
   logic [2:0] req_range_index = 0;
   logic [7:0] req_permissions = 0;
   logic [3:0] req_lock_request = 0;
   logic rsp_valid, rsp_ready = 0, rsp_accepted;
   logic [2:0] rsp_status;
   logic [3:0] rsp_lock_bits;

   guard_scoreboard board;
   int hold_off = 0;
   bit stalling_on = 0;
   int sent = 0;

   flash_region_access_guard dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_action(req_action),
      .req_initiator(req_initiator), .req_address(req_address),
      .req_length(req_length), .req_write_op(req_write_op),
      .req_range_index(req_range_index), .req_range_base(req_range_base),
      .req_range_limit(req_range_limit), .req_permissions(req_permissions),
      .req_lock_request(req_lock_request), .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready), .rsp_accepted(rsp_accepted),
      .rsp_status(rsp_status), .rsp_lock_bits(rsp_lock_bits)
   );

   always #5 clock = ~clock;

   // receiver: random stalls, plus one long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready)
            board.check_response(rsp_accepted, rsp_status, rsp_lock_bits);
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_ready <= 0;
         end else if (stalling_on) begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   task automatic send(action_type act, logic [1:0] m, logic [23:0] addr,
                       logic [12:0] len, logic wr, logic [2:0] idx, logic [23:0] b,
                       logic [23:0] l, logic [7:0] perm, logic [3:0] lreq);
      req_valid <= 1;
      req_action <= act;
      req_initiator <= m;
      req_address <= addr;
      req_length <= len;
      req_write_op <= wr;
      req_range_index <= idx;
      req_range_base <= b;
      req_range_limit <= l;
      req_permissions <= perm;
      req_lock_request <= lreq;
      do @(posedge clock); while (!req_ready);
      board.note_request(act, m, addr, len, wr, idx, b, l, perm, lreq);
      sent++;
   endtask

   task automatic pause_sender();
      req_valid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.verdicts.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_host(logic [1:0] v);
      csr_we <= 1;
      csr_wdata <= v;
      board.host_id = v;
      @(posedge clock);
      csr_we <= 0;
   endtask

   // random check, mostly short accesses near region edges
   task automatic rand_check();
      logic [23:0] a;
      logic [12:0] n;
      case ($urandom_range(0, 5))
         0: a = 24'($urandom);
         1: a = 24'h600000 - 24'($urandom_range(0, 64));
         2: a = 24'hA00000 - 24'($urandom_range(0, 64));
         3: a = 24'hC00000 - 24'($urandom_range(0, 64));
         4: a = 24'hFFFFFF - 24'($urandom_range(0, 64));
         default: a = board.rng_base[$urandom_range(0, NUM_SLOTS-1)]
                      - 24'($urandom_range(0, 8));
      endcase
      case ($urandom_range(0, 9))
         0: n = 13'($urandom);
         1: n = 13'd4096 + 13'($urandom_range(0, 1));
         2: n = 0;
         default: n = 13'($urandom_range(1, 40));
      endcase
      send(ACT_CHECK, 2'($urandom), a, n, 1'($urandom), 3'($urandom), 24'($urandom),
           24'($urandom), 8'($urandom), 4'($urandom));
   endtask

   task automatic rand_set();
      logic [23:0] b, l;
      b = 24'($urandom);
      l = ($urandom_range(0, 5) == 0) ? 24'($urandom) : 24'(b + $urandom_range(0, 300));
      send(ACT_SET, 2'($urandom), 24'($urandom), 13'($urandom), 1'($urandom),
           ($urandom_range(0, 5) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4)),
           b, l, 8'($urandom), 4'($urandom));
   endtask

   task automatic random_phase(int count, bit lock_ok);
      int burst;
      burst = 0;
      for (int i = 0; i < count; i++) begin
         if (burst == 0) begin
            pause_sender();
            burst = $urandom_range(1, 30);
         end
         burst--;
         case ($urandom_range(0, 19))
            0, 1, 2: rand_set();
            3: if (lock_ok) send(ACT_LOCK, 2'($urandom), 24'($urandom), 13'($urandom),
                                 1'($urandom), 3'($urandom), 24'($urandom),
                                 24'($urandom), 8'($urandom),
                                 4'($urandom_range(0, 7)));
               else rand_check();
            4: send(ACT_NONE, 2'($urandom), 24'($urandom), 13'($urandom), 1'($urandom),
                    3'($urandom), 24'($urandom), 24'($urandom), 8'($urandom),
                    4'($urandom));
            default: rand_check();
         endcase
      end
      drain();
   endtask

   initial begin
      board = new();
      board.clear();
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      stalling_on = 1;

      // directed: region edges, bounds, ranges, host write rule
      send(ACT_CHECK, 2'd0, 24'h000000, 13'd0, 0, 0, 0, 0, 0, 0);
      send(ACT_CHECK, 2'd1, 24'h5FFFFE, 13'd4, 0, 0, 0, 0, 0, 0);
      send(ACT_CHECK, 2'd2, 24'h9FFFFF, 13'd1, 1, 0, 0, 0, 0, 0);
      send(ACT_CHECK, 2'd3, 24'hBFFFFF, 13'd2, 0, 0, 0, 0, 0, 0);
      send(ACT_CHECK, 2'd0, 24'hFFFFFF, 13'd1, 0, 0, 0, 0, 0, 0);
      send(ACT_CHECK, 2'd0, 24'hFFFFFF, 13'd2, 0, 0, 0, 0, 0, 0);
      send(ACT_CHECK, 2'd1, 24'h000000, 13'd4097, 0, 0, 0, 0, 0, 0);
      send(ACT_CHECK, 2'd1, 24'h000000, 13'h1FFF, 1, 0, 0, 0, 0, 0);
      send(ACT_CHECK, 2'd0, 24'h100000, 13'd4096, 1, 0, 0, 0, 0, 0);
      send(ACT_SET, 0, 0, 0, 0, 3'd0, 24'h000010, 24'h00001F, 8'h01, 0);
      send(ACT_SET, 0, 0, 0, 0, 3'd4, 24'h000000, 24'hFFFFFF, 8'hFE, 0);
      send(ACT_SET, 0, 0, 0, 0, 3'd7, 24'h0, 24'h1, 8'h03, 0);
      send(ACT_SET, 0, 0, 0, 0, 3'd5, 24'h0, 24'h1, 8'h03, 0);
      send(ACT_SET, 0, 0, 0, 0, 3'd1, 24'h000002, 24'h000001, 8'h03, 0);
      send(ACT_CHECK, 2'd1, 24'h00000C, 13'd8, 1, 0, 0, 0, 0, 0);
      send(ACT_CHECK, 2'd1, 24'h00000C, 13'd8, 0, 0, 0, 0, 0, 0);
      send(ACT_CHECK, 2'd2, 24'hFFFFFF, 13'd1, 0, 0, 0, 0, 0, 0);
      send(ACT_SET, 0, 0, 0, 0, 3'd4, 24'hFFFFFF, 24'h000000, 8'hFF, 0);
      send(ACT_LOCK, 0, 0, 0, 0, 0, 0, 0, 0, 4'h1);
      send(ACT_CHECK, 2'd0, 24'h000100, 13'd4, 1, 0, 0, 0, 0, 0);
      send(ACT_NONE, 2'd3, 24'hFFFFFF, 13'h1FFF, 1, 3'd7, 24'hFFFFFF, 24'hFFFFFF,
           8'hFF, 4'hF);
      drain();
      write_host(2'd3);

      // long receiver hold-off while the sender keeps offering
      hold_off = 400;
      random_phase(300, 0);
      write_host(2'd1);
      stalling_on = 0;
      random_phase(400, 0);
      stalling_on = 1;
      write_host(2'd2);
      random_phase(400, 1);
      write_host(2'd0);
      random_phase(400, 0);
      send(ACT_LOCK, 0, 0, 0, 0, 0, 0, 0, 0, 4'hF);
      send(ACT_LOCK, 0, 0, 0, 0, 0, 0, 0, 0, 4'h1);
      send(ACT_SET, 0, 0, 0, 0, 3'd2, 24'h0, 24'h10, 8'h0, 0);
      random_phase(60, 1);

      $display("Sent %0d transactions (checks, range sets, locks, unknown actions);",
               sent);
      $display("checked %0d responses over four host settings and lockdown.",
               board.checked);
      if (board.errors == 0 && board.verdicts.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #400000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/frag_pkg.sv
rtl/core/frag_front.sv
rtl/core/frag_queue.sv
rtl/core/frag_back.sv
rtl/core/flash_region_access_guard.sv
rtl/core/frag_checker.sv
bench/tb_flash_region_access_guard.sv
